// ===== rtl/csf_pkg.sv =====
package csf_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd1;

	// Field widths fixed by the register map
	localparam int ROW_LEN_CFG_W = 11;
	localparam int ROW_W         = 16;

	// Result queue sizing
	localparam int RES_PER_ITEM = 3;
	localparam int OUTQ_DEPTH   = 8;
	localparam int OUTQ_PTR_W   = $clog2(OUTQ_DEPTH);

endpackage

// ===== rtl/cross_stencil_smoothing_filter.sv =====
// Five-point cross smoothing over a raster-ordered height grid: each point becomes
// (4*centre + left + right + up + down) >> 3 (floor), with off-grid neighbours replaced
// by the centre. Point (c, r-1) comes out when sample (c, r) is taken; during the last
// row of a frame that row's points come out as well, so one sample yields up to three
// results. Two line stores (synchronous RAMs, MAX_COLS entries each) hold rows r-2 and
// r-1. One sample is taken per clock while the output is drained; in the last row of a
// frame the single result port sets the pace, as a sample there can yield more than
// one result. Each result passes through the stage 1 registers and the output queue,
// and up to eight results are buffered at the output. Writing either register restarts the
// frame at column 0, row 0; write them only while the block is idle.
module cross_stencil_smoothing_filter #(
	parameter int MAX_COLS    = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Sample input
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	// Result output
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [$clog2(MAX_COLS)-1:0]          out_col,
	output logic [csf_pkg::ROW_W-1:0]            out_row,
	output logic signed [SAMPLE_BITS-1:0]        smoothed,
	output logic                                 run_last,
	output logic                                 frame_done,
	// Configuration
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [csf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [csf_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import csf_pkg::*;

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int LEN_W  = $clog2(MAX_COLS + 1);
	localparam int SB     = SAMPLE_BITS;
	localparam int SUM_W  = SAMPLE_BITS + 3;
	localparam int DATA_W = COL_W + ROW_W + SAMPLE_BITS + 2;

	// (4*c + l + r + u + d) >> 3, floor
	function automatic logic signed [SB-1:0] smooth5(
		input logic signed [SB-1:0] c,
		input logic signed [SB-1:0] l,
		input logic signed [SB-1:0] r,
		input logic signed [SB-1:0] u,
		input logic signed [SB-1:0] d
	);
		logic signed [SUM_W-1:0] sum;
		sum = (SUM_W'(c) <<< 2) + SUM_W'(l) + SUM_W'(r) + SUM_W'(u) + SUM_W'(d);
		return sum[SUM_W-1:3];
	endfunction

	// Line stores: previous row (r-1) and older row (r-2)
	logic signed [SB-1:0] prev_mem  [MAX_COLS];
	logic signed [SB-1:0] older_mem [MAX_COLS];

	// Configuration and position
	logic [LEN_W-1:0]  row_len_q;
	logic [ROW_W-1:0]  row_cnt_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [31:0]       len_wr;

	// Stage 1: sample, position and store read data
	logic                  s1_valid_q;
	logic signed [SB-1:0]  sample_s1;
	logic [COL_W-1:0]      col_s1;
	logic [ROW_W-1:0]      row_s1;
	logic                  last_col_s1;
	logic                  last_row_s1;
	logic signed [SB-1:0]  pu_rd_s1;
	logic signed [SB-1:0]  pr_rd_s1;
	logic signed [SB-1:0]  ou_rd_s1;
	logic                  fwd_c_s1;
	logic                  fwd_n_s1;
	logic signed [SB-1:0]  fwd_prev_s1;
	logic signed [SB-1:0]  fwd_old_s1;

	// History of the current row
	logic signed [SB-1:0]  samp_d1_q;
	logic signed [SB-1:0]  samp_d2_q;
	logic signed [SB-1:0]  pu_d1_q;

	logic                  in_accept;
	logic                  cfg_accept;
	logic                  last_col;
	logic                  last_row;
	logic [COL_W-1:0]      col_nxt_addr;

	logic signed [SB-1:0]  pu, ou, pr;
	logic signed [SB-1:0]  sm1, sm2, sm3;
	logic                  v1, v2, v3;
	logic                  c_ge1, c_ge2, r_ge1, r_ge2;

	logic [RES_PER_ITEM-1:0]              push_valid;
	logic [RES_PER_ITEM-1:0][DATA_W-1:0]  push_data;
	logic [OUTQ_PTR_W:0]                  q_level;
	logic [DATA_W-1:0]                    pop_data;

	assign cfg_ready  = 1'b1;
	assign cfg_accept = cfg_valid && cfg_ready;
	assign in_accept  = in_valid && in_ready;

	// Admit a sample only if the queue can absorb the stage 1 request and this one
	assign in_ready = s1_valid_q ? (q_level <= (OUTQ_PTR_W+1)'(OUTQ_DEPTH - 2*RES_PER_ITEM))
	                             : (q_level <= (OUTQ_PTR_W+1)'(OUTQ_DEPTH - RES_PER_ITEM));

	assign last_col     = (LEN_W'(col_q) + LEN_W'(1)) == row_len_q;
	assign last_row     = row_q == (row_cnt_q - ROW_W'(1));
	assign col_nxt_addr = col_q + COL_W'(1);
	assign len_wr       = 32'(cfg_data[ROW_LEN_CFG_W-1:0]);

	// Registers and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// default length 256, held to the line store size
			row_len_q  <= LEN_W'((MAX_COLS < 256) ? MAX_COLS : 256);
			row_cnt_q  <= ROW_W'(256);
			col_q      <= '0;
			row_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= in_accept;
			if (cfg_accept) begin
				if (cfg_index == REG_ROW_LENGTH) begin
					if (len_wr == 32'd0) begin
						row_len_q <= LEN_W'(1);
					end else if (len_wr > 32'(MAX_COLS)) begin
						row_len_q <= LEN_W'(MAX_COLS);
					end else begin
						row_len_q <= LEN_W'(len_wr);
					end
					col_q <= '0;
					row_q <= '0;
				end else if (cfg_index == REG_ROW_COUNT) begin
					row_cnt_q <= (cfg_data[ROW_W-1:0] == '0) ? ROW_W'(1) : cfg_data[ROW_W-1:0];
					col_q     <= '0;
					row_q     <= '0;
				end
			end else if (in_accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// Line store read (at accept) and write-back (in stage 1)
	always_ff @(posedge clk) begin
		if (in_accept) begin
			pu_rd_s1    <= prev_mem[col_q];
			pr_rd_s1    <= prev_mem[col_nxt_addr];
			ou_rd_s1    <= older_mem[col_q];
			// stage 1 writes at this same edge; catch it for the entries we read
			fwd_c_s1    <= s1_valid_q && (col_s1 == col_q);
			fwd_n_s1    <= s1_valid_q && (col_s1 == col_nxt_addr);
			fwd_prev_s1 <= sample_s1;
			fwd_old_s1  <= pu;
			sample_s1   <= sample;
			col_s1      <= col_q;
			row_s1      <= row_q;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
		end
		if (s1_valid_q) begin
			older_mem[col_s1] <= pu;
			prev_mem[col_s1]  <= sample_s1;
			samp_d1_q         <= sample_s1;
			samp_d2_q         <= samp_d1_q;
			pu_d1_q           <= pu;
		end
	end

	// Stage 1 neighbours with forwarding
	assign pu = fwd_c_s1 ? fwd_prev_s1 : pu_rd_s1;
	assign ou = fwd_c_s1 ? fwd_old_s1  : ou_rd_s1;
	assign pr = fwd_n_s1 ? fwd_prev_s1 : pr_rd_s1;

	assign c_ge1 = (col_s1 != '0);
	assign c_ge2 = (col_s1 > COL_W'(1));
	assign r_ge1 = (row_s1 != '0);
	assign r_ge2 = (row_s1 > ROW_W'(1));

	// The three candidate results: (c,r-1), (c-1,r), (c,r)
	always_comb begin
		sm1 = smooth5(pu, c_ge1 ? pu_d1_q : pu, last_col_s1 ? pu : pr,
		              r_ge2 ? ou : pu, sample_s1);
		sm2 = smooth5(samp_d1_q, c_ge2 ? samp_d2_q : samp_d1_q, sample_s1,
		              r_ge1 ? pu_d1_q : samp_d1_q, samp_d1_q);
		sm3 = smooth5(sample_s1, c_ge1 ? samp_d1_q : sample_s1, sample_s1,
		              r_ge1 ? pu : sample_s1, sample_s1);
		v1  = s1_valid_q && r_ge1;
		v2  = s1_valid_q && last_row_s1 && c_ge1;
		v3  = s1_valid_q && last_row_s1 && last_col_s1;
	end

	assign push_valid   = {v3, v2, v1};
	assign push_data[0] = {col_s1, row_s1 - ROW_W'(1), sm1, (!v2 && !v3), 1'b0};
	assign push_data[1] = {col_s1 - COL_W'(1), row_s1, sm2, !v3, 1'b0};
	assign push_data[2] = {col_s1, row_s1, sm3, 1'b1, 1'b1};

	csf_outq #(
		.DATA_W (DATA_W)
	) u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.level      (q_level),
		.pop_valid  (out_valid),
		.pop_ready  (out_ready),
		.pop_data   (pop_data)
	);

	assign {out_col, out_row, smoothed, run_last, frame_done} = pop_data;

endmodule

// ===== rtl/csf_outq.sv =====
module csf_outq #(
	parameter int DATA_W = 44
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic [csf_pkg::RES_PER_ITEM-1:0]               push_valid,
	input  logic [csf_pkg::RES_PER_ITEM-1:0][DATA_W-1:0]   push_data,
	output logic [csf_pkg::OUTQ_PTR_W:0]                   level,
	output logic                                           pop_valid,
	input  logic                                           pop_ready,
	output logic [DATA_W-1:0]                              pop_data
);
	import csf_pkg::*;

	logic [DATA_W-1:0]       slots_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0]   wr_ptr_q;
	logic [OUTQ_PTR_W-1:0]   rd_ptr_q;
	logic [OUTQ_PTR_W:0]     count_q;
	logic [OUTQ_PTR_W-1:0]   offs [RES_PER_ITEM];
	logic [OUTQ_PTR_W-1:0]   push_cnt;
	logic                    pop;

	// Compact the valid pushes into consecutive slots, in order
	always_comb begin
		push_cnt = '0;
		for (int i = 0; i < RES_PER_ITEM; i++) begin
			offs[i] = push_cnt;
			push_cnt = push_cnt + OUTQ_PTR_W'(push_valid[i]);
		end
	end

	assign pop       = pop_valid && pop_ready;
	assign pop_valid = (count_q != '0);
	assign pop_data  = slots_q[rd_ptr_q];
	assign level     = count_q;

	// Storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < RES_PER_ITEM; i++) begin
			if (push_valid[i]) begin
				slots_q[wr_ptr_q + offs[i]] <= push_data[i];
			end
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_cnt;
			rd_ptr_q <= rd_ptr_q + OUTQ_PTR_W'(pop);
			count_q  <= count_q + (OUTQ_PTR_W+1)'(push_cnt) - (OUTQ_PTR_W+1)'(pop);
		end
	end

endmodule

// ===== verif/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import csf_pkg::*;

	localparam int MAX_COLS      = 1024;
	localparam int SAMPLE_BITS   = 16;
	localparam int COL_W         = $clog2(MAX_COLS);
	// results pass through stage 1 and the output queue, eight can sit in the output buffer
	localparam int SETTLE_CYCLES = 16;
	// far beyond what a good run needs
	localparam int CYCLE_LIMIT   = 200000;
	// random part; the directed frames add the rest of the samples
	localparam int RANDOM_ITEMS  = 134;
	// unmapped register index, must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef logic signed [SAMPLE_BITS-1:0] height_t;

	typedef struct {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		height_t          value;
		logic             last;
		logic             done;
	} grid_point_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	height_t               sample     = '0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic [COL_W-1:0]      out_col;
	logic [ROW_W-1:0]      out_row;
	height_t               smoothed;
	logic                  run_last;
	logic                  frame_done;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	// Shadow copy of the filter state
	height_t older_line [MAX_COLS];
	height_t prev_line [MAX_COLS];
	int      col_pos;
	int      row_pos;
	int      row_len;
	int      row_cnt;

	height_t     pending_samples [$];
	grid_point_t expected_points [$];
	int          error_count   = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          cycle_count   = 0;

	cross_stencil_smoothing_filter #(
		.MAX_COLS   (MAX_COLS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_col   (out_col),
		.out_row   (out_row),
		.smoothed  (smoothed),
		.run_last  (run_last),
		.frame_done(frame_done),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(string msg);
		error_count++;
		$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	// (4*centre + neighbours) >> 3, floor for negative sums
	function automatic height_t stencil_avg(int centre, int left, int right, int up, int down);
		int total;
		total = 4 * centre + left + right + up + down;
		return height_t'(total >>> 3);
	endfunction

	// Register write: clamp to legal geometry, restart the frame
	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		int v;
		case (idx)
			REG_ROW_LENGTH: begin
				v = int'(data[ROW_LEN_CFG_W-1:0]);
				row_len = (v < 1) ? 1 : (v > MAX_COLS) ? MAX_COLS : v;
			end
			REG_ROW_COUNT: begin
				row_cnt = (data == '0) ? 1 : int'(data);
			end
			default: begin
				return;
			end
		endcase
		col_pos = 0;
		row_pos = 0;
	endfunction

	// Work out the points released by one accepted sample
	function automatic void predict_points(height_t height);
		int          c;
		int          r;
		int          n;
		logic        last_c;
		logic        last_r;
		height_t     up;
		height_t     left;
		grid_point_t pt;
		grid_point_t pts [$];
		c = (col_pos >= row_len) ? row_len - 1 : col_pos;
		r = (row_pos >= row_cnt) ? row_cnt - 1 : row_pos;
		last_c = (c + 1 == row_len);
		last_r = (r + 1 == row_cnt);
		up = prev_line[c];
		left = (c >= 1) ? prev_line[c-1] : height_t'(0);
		pt.last = 1'b0;
		pt.done = 1'b0;

		// point above the current sample
		if (r >= 1) begin
			pt.col = COL_W'(c);
			pt.row = ROW_W'(r - 1);
			pt.value = stencil_avg(up, (c >= 1) ? older_line[c-1] : up,
				(c + 1 < row_len) ? prev_line[c+1] : up,
				(r >= 2) ? older_line[c] : up, height);
			pts.push_back(pt);
		end
		// bottom row: point to the left of the current sample
		if (last_r && c >= 1) begin
			pt.col = COL_W'(c - 1);
			pt.row = ROW_W'(r);
			pt.value = stencil_avg(left, (c >= 2) ? prev_line[c-2] : left, height,
				(r >= 1) ? older_line[c-1] : left, left);
			pts.push_back(pt);
		end
		// bottom right corner: the sample itself
		if (last_r && last_c) begin
			pt.col = COL_W'(c);
			pt.row = ROW_W'(r);
			pt.value = stencil_avg(height, (c >= 1) ? left : height, height,
				(r >= 1) ? up : height, height);
			pts.push_back(pt);
		end

		older_line[c] = up;
		prev_line[c] = height;
		if (last_c) begin
			col_pos = 0;
			row_pos = last_r ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end

		n = pts.size();
		if (n > 0) begin
			pts[n-1].last = 1'b1;
			pts[n-1].done = last_r && last_c;
		end
		foreach (pts[i]) begin
			expected_points.push_back(pts[i]);
		end
	endfunction

	function automatic height_t rand_height();
		case ($urandom_range(9))
			0: begin
				return 16'sh7FFF;
			end
			1: begin
				return 16'sh8000;
			end
			2: begin
				return height_t'(int'($urandom_range(0, 31)) - 16);
			end
			default: begin
				return height_t'($urandom);
			end
		endcase
	endfunction

	// Sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_points(sample);
			end
			if (!in_valid || in_ready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					sample <= pending_samples.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin : result_monitor
		grid_point_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					report_mismatch($sformatf("unexpected result at (%0d,%0d) value %0d",
						out_col, out_row, smoothed));
				end else begin
					want = expected_points.pop_front();
					if (out_col !== want.col) begin
						report_mismatch($sformatf("out_col %0d, want %0d", out_col, want.col));
					end
					if (out_row !== want.row) begin
						report_mismatch($sformatf("out_row %0d, want %0d", out_row, want.row));
					end
					if (smoothed !== want.value) begin
						report_mismatch($sformatf("smoothed %0d at (%0d,%0d), want %0d",
							smoothed, want.col, want.row, want.value));
					end
					if (run_last !== want.last) begin
						report_mismatch($sformatf("run_last %b at (%0d,%0d), want %b",
							run_last, want.col, want.row, want.last));
					end
					if (frame_done !== want.done) begin
						report_mismatch($sformatf("frame_done %b at (%0d,%0d), want %b",
							frame_done, want.col, want.row, want.done));
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic wait_for_idle();
		do begin
			@(posedge clk);
		end while (pending_samples.size() != 0 || in_valid || expected_points.size() != 0);
	endtask

	// Idle, plus time for samples that release no point to leave the pipeline
	task automatic settle();
		wait_for_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_register(idx, data);
	endtask

	task automatic queue_burst(height_t vals [$]);
		foreach (vals[i]) begin
			pending_samples.push_back(vals[i]);
		end
	endtask

	initial begin : stimulus
		height_t burst [$];
		int      len;
		int      rows;
		int      count;
		int      split;
		int      sent;
		int      phase_no;

		foreach (older_line[i]) begin
			older_line[i] = '0;
			prev_line[i] = '0;
		end
		col_pos = 0;
		row_pos = 0;
		row_len = 256;
		row_cnt = 256;
		send_idle_pct = 34;
		recv_idle_pct = 68;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset geometry: still in the first row, nothing may come out
		burst = '{16'sh0000, 16'shFFFF};
		queue_burst(burst);
		settle();

		// 3x3 frame of alternating extremes, then the start of the next frame
		write_register(REG_ROW_LENGTH, 16'd3);
		write_register(REG_ROW_COUNT, 16'd3);
		burst = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
			16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh0000, 16'sh0001};
		queue_burst(burst);
		settle();

		// zero length and zero count both act as one: a 1x1 grid
		write_register(REG_ROW_LENGTH, 16'd0);
		write_register(REG_ROW_COUNT, 16'd0);
		burst = '{16'sh8000, 16'sh7FFF};
		queue_burst(burst);
		settle();

		// oversized row length clamps to the full line store, single-row frame
		write_register(REG_ROW_LENGTH, 16'hFFFF);
		write_register(REG_ROW_COUNT, 16'd1);
		burst = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh0005};
		queue_burst(burst);
		settle();

		// tallest frame, narrow rows; a write to the spare index must not restart
		write_register(REG_ROW_LENGTH, 16'd2);
		write_register(REG_ROW_COUNT, 16'hFFFF);
		burst = '{16'sh0100, 16'shFF00, 16'sh7FFF};
		queue_burst(burst);
		settle();
		write_register(REG_SPARE, 16'hFFFF);
		burst = '{16'sh8000, 16'sh1234, 16'shEDCB};
		queue_burst(burst);
		settle();

		// Random frames: mostly whole small grids, some trailing partial rows
		sent = 0;
		phase_no = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent < RANDOM_ITEMS / 3) begin
				send_idle_pct = 34;
				recv_idle_pct = 68;
			end else if (sent < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 68;
				recv_idle_pct = 34;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			if ($urandom_range(9) == 0) begin
				// wide single-row grid, only the first few points fed
				len = $urandom_range(512, MAX_COLS);
				rows = 1;
				count = $urandom_range(4, 12);
			end else begin
				len = $urandom_range(1, 6);
				rows = $urandom_range(1, 5);
				count = len * rows * (($urandom_range(3) == 0) ? 2 : 1) + $urandom_range(0, len);
			end
			// keep the total near the planned number of samples
			if (count > RANDOM_ITEMS - sent) begin
				count = RANDOM_ITEMS - sent;
			end
			if ($urandom_range(1) == 0) begin
				write_register(REG_ROW_LENGTH, CFG_DATA_W'(len));
				write_register(REG_ROW_COUNT, CFG_DATA_W'(rows));
			end else begin
				write_register(REG_ROW_COUNT, CFG_DATA_W'(rows));
				write_register(REG_ROW_LENGTH, CFG_DATA_W'(len));
			end

			// now and then hold the sender until every pending point is out
			split = (phase_no % 4 == 1 || $urandom_range(4) == 0) ?
				$urandom_range(1, count) : count;
			for (int i = 0; i < count; i++) begin
				if (i == split) begin
					wait_for_idle();
				end
				pending_samples.push_back(rand_height());
			end
			sent += count;
			phase_no++;
			settle();
		end

		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

endmodule
